FILE: rtl/core/nsp_pkg.sv
`default_nettype none

package nsp_pkg;

  // Nibbles a data transaction may carry.
  localparam int DataNibbles = 16;
  localparam int DataBits    = 4 * DataNibbles;

  // A job holds at least the five nibbles of an instruction.
  localparam int JobNibbles  = (DataNibbles > 5) ? DataNibbles : 5;
  localparam int JobBits     = 4 * JobNibbles;
  localparam int CntBits     = $clog2(JobNibbles + 1);

  localparam int InstrNibbles = 5;
  localparam int ByteNibbles  = 2;

  typedef enum logic [2:0] {
    MODE_INSTR = 3'd0,
    MODE_DATA  = 3'd1,
    MODE_CHAR  = 3'd2,
    MODE_RAW   = 3'd3,
    MODE_FLUSH = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    JOB_PACK  = 2'd0,
    JOB_ERROR = 2'd1,
    JOB_FLUSH = 2'd2
  } job_kind_t;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ESC = 1'b1;

  // One unit of back-end work; nibbles are left aligned, first one on top.
  typedef struct packed {
    job_kind_t            kind;
    logic [JobBits-1:0]   nibbles;
    logic [CntBits-1:0]   count;
  } job_t;

  // Queue write side.
  typedef struct packed {
    logic push;
    job_t job;
  } queue_wr_t;

  // Queue read side status.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/nsp_if.sv
`default_nettype none

interface nsp_item_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [3:0]  opcode;
  logic [15:0] address;
  logic [63:0] data_value;
  logic [4:0]  nibble_count;
  logic [7:0]  text_char;

  modport source (
    output valid, mode, opcode, address, data_value, nibble_count, text_char,
    input  ready
  );
  modport sink (
    input  valid, mode, opcode, address, data_value, nibble_count, text_char,
    output ready
  );
endinterface

interface nsp_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       status;
  logic       last;

  modport source (output valid, out_byte, status, last, input ready);
  modport sink   (input  valid, out_byte, status, last, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/nsp_front.sv
`default_nettype none

module nsp_front (
  input  wire logic                 clk,
  input  wire logic                 rst,
  nsp_item_if.sink                  item,
  input  wire nsp_pkg::queue_stat_t q_stat,
  output nsp_pkg::queue_wr_t        q_wr
);

  logic escape;
  logic escape_next;
  logic accept;

  logic [nsp_pkg::CntBits-1:0] dcnt;
  logic [nsp_pkg::CntBits-1:0] dshift;
  logic [nsp_pkg::JobBits-1:0] dwin;
  logic [8:0]                  esc_dec;

  // {known, code}
  function automatic logic [8:0] decode_escape(input logic [7:0] c);
    logic [8:0] r;
    case (c)
      8'h30:   r = {1'b1, 8'd0};   // 0
      8'h61:   r = {1'b1, 8'd7};   // a
      8'h62:   r = {1'b1, 8'd8};   // b
      8'h66:   r = {1'b1, 8'd12};  // f
      8'h6E:   r = {1'b1, 8'd10};  // n
      8'h72:   r = {1'b1, 8'd13};  // r
      8'h74:   r = {1'b1, 8'd9};   // t
      8'h76:   r = {1'b1, 8'd11};  // v
      8'h27:   r = {1'b1, 8'h27};  // single quote
      8'h22:   r = {1'b1, 8'h22};  // double quote
      8'h5C:   r = {1'b1, 8'h5C};  // backslash
      8'h3F:   r = {1'b1, 8'h3F};  // question mark
      default: r = {1'b0, 8'd0};
    endcase
    return r;
  endfunction

  assign item.ready = !q_stat.full;
  assign accept     = item.valid && item.ready;

  always_comb begin
    if (item.nibble_count > 5'(nsp_pkg::DataNibbles)) begin
      dcnt = nsp_pkg::CntBits'(nsp_pkg::DataNibbles);
    end else begin
      dcnt = nsp_pkg::CntBits'(item.nibble_count);
    end
    dshift  = nsp_pkg::CntBits'(nsp_pkg::JobNibbles) - dcnt;
    dwin    = nsp_pkg::JobBits'(item.data_value[nsp_pkg::DataBits-1:0]);
    esc_dec = decode_escape(item.text_char);
  end

  always_comb begin
    escape_next       = escape;
    q_wr.push         = 1'b0;
    q_wr.job.kind     = nsp_pkg::JOB_PACK;
    q_wr.job.nibbles  = '0;
    q_wr.job.count    = '0;
    case (item.mode)
      nsp_pkg::MODE_INSTR: begin
        escape_next      = 1'b0;
        q_wr.push        = accept;
        q_wr.job.nibbles = nsp_pkg::JobBits'({item.opcode, item.address})
                           << (nsp_pkg::JobBits - 20);
        q_wr.job.count   = nsp_pkg::CntBits'(nsp_pkg::InstrNibbles);
      end
      nsp_pkg::MODE_DATA: begin
        escape_next      = 1'b0;
        q_wr.push        = accept && (dcnt != '0);
        q_wr.job.nibbles = dwin << {dshift, 2'b00};
        q_wr.job.count   = dcnt;
      end
      nsp_pkg::MODE_CHAR: begin
        if (escape) begin
          escape_next = 1'b0;
          q_wr.push   = accept;
          if (esc_dec[8]) begin
            q_wr.job.nibbles = nsp_pkg::JobBits'(esc_dec[7:0])
                               << (nsp_pkg::JobBits - 8);
            q_wr.job.count   = nsp_pkg::CntBits'(nsp_pkg::ByteNibbles);
          end else begin
            q_wr.job.kind = nsp_pkg::JOB_ERROR;
          end
        end else if (item.text_char == 8'h5C) begin
          escape_next = 1'b1;  // marker only, nothing queued
        end else begin
          q_wr.push        = accept;
          q_wr.job.nibbles = nsp_pkg::JobBits'(item.text_char)
                             << (nsp_pkg::JobBits - 8);
          q_wr.job.count   = nsp_pkg::CntBits'(nsp_pkg::ByteNibbles);
        end
      end
      nsp_pkg::MODE_RAW: begin
        escape_next      = 1'b0;
        q_wr.push        = accept;
        q_wr.job.nibbles = nsp_pkg::JobBits'(item.text_char)
                           << (nsp_pkg::JobBits - 8);
        q_wr.job.count   = nsp_pkg::CntBits'(nsp_pkg::ByteNibbles);
      end
      nsp_pkg::MODE_FLUSH: begin
        escape_next   = 1'b0;
        q_wr.push     = accept;
        q_wr.job.kind = nsp_pkg::JOB_FLUSH;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      escape <= 1'b0;
    end else if (accept) begin
      escape <= escape_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/nsp_queue.sv
`default_nettype none

module nsp_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire nsp_pkg::queue_wr_t wr,
  input  wire logic               pop,
  output nsp_pkg::job_t           head,
  output nsp_pkg::queue_stat_t    stat
);

  nsp_pkg::job_t mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] fill;
  logic       do_push;
  logic       do_pop;

  assign stat.full  = (fill == 2'd2);
  assign stat.empty = (fill == 2'd0);
  assign do_push    = wr.push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wr.job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (do_push) wptr <= !wptr;
      if (do_pop)  rptr <= !rptr;
      fill <= fill + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/nsp_back.sv
`default_nettype none

module nsp_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire nsp_pkg::job_t        head,
  input  wire nsp_pkg::queue_stat_t q_stat,
  output logic                      pop,
  nsp_result_if.source              result
);

  logic                        busy, busy_next;
  nsp_pkg::job_kind_t          kind, kind_next;
  logic [nsp_pkg::JobBits-1:0] shreg, shreg_next;
  logic [nsp_pkg::CntBits-1:0] rem, rem_next;
  logic [3:0]                  pend, pend_next;
  logic                        pend_valid, pend_valid_next;
  logic                        out_valid, out_valid_next;
  logic [7:0]                  out_byte, out_byte_next;
  logic                        out_status, out_status_next;
  logic                        out_last, out_last_next;
  logic                        advance;
  logic [3:0]                  nib;

  assign result.valid    = out_valid;
  assign result.out_byte = out_byte;
  assign result.status   = out_status;
  assign result.last     = out_last;

  assign advance = busy && (!out_valid || result.ready);
  assign pop     = !busy && !q_stat.empty;
  assign nib     = shreg[nsp_pkg::JobBits-1 -: 4];

  always_comb begin
    busy_next       = busy;
    kind_next       = kind;
    shreg_next      = shreg;
    rem_next        = rem;
    pend_next       = pend;
    pend_valid_next = pend_valid;
    out_valid_next  = out_valid && !result.ready;
    out_byte_next   = out_byte;
    out_status_next = out_status;
    out_last_next   = out_last;

    if (pop) begin
      busy_next  = 1'b1;
      kind_next  = head.kind;
      shreg_next = head.nibbles;
      rem_next   = head.count;
    end else if (advance) begin
      case (kind)
        nsp_pkg::JOB_PACK: begin
          if (pend_valid) begin
            out_valid_next  = 1'b1;
            out_byte_next   = {pend, nib};
            out_status_next = nsp_pkg::STATUS_OK;
            out_last_next   = (rem <= nsp_pkg::CntBits'(2));
            pend_valid_next = 1'b0;
            pend_next       = 4'd0;
          end else begin
            pend_next       = nib;
            pend_valid_next = 1'b1;
          end
          shreg_next = shreg << 4;
          rem_next   = rem - nsp_pkg::CntBits'(1);
          busy_next  = (rem > nsp_pkg::CntBits'(1));
        end
        nsp_pkg::JOB_ERROR: begin
          out_valid_next  = 1'b1;
          out_byte_next   = 8'd0;
          out_status_next = nsp_pkg::STATUS_ESC;
          out_last_next   = 1'b1;
          busy_next       = 1'b0;
        end
        nsp_pkg::JOB_FLUSH: begin
          if (pend_valid) begin
            out_valid_next  = 1'b1;
            out_byte_next   = {pend, 4'd0};
            out_status_next = nsp_pkg::STATUS_OK;
            out_last_next   = 1'b1;
          end
          pend_valid_next = 1'b0;
          pend_next       = 4'd0;
          busy_next       = 1'b0;
        end
        default: begin
          busy_next = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      pend       <= 4'd0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      busy       <= busy_next;
      pend       <= pend_next;
      pend_valid <= pend_valid_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    kind       <= kind_next;
    shreg      <= shreg_next;
    rem        <= rem_next;
    out_byte   <= out_byte_next;
    out_status <= out_status_next;
    out_last   <= out_last_next;
  end

endmodule

`default_nettype wire

FILE: rtl/core/nibble_stream_packer.sv
`default_nettype none

// Channel  Dir  Fields                                            Accept
// item     in   mode opcode address data_value nibble_count      valid && ready
//               text_char
// result   out  out_byte status last                              valid && ready
//
// A transaction is classified in the cycle it is accepted and queued as a job
// (two-entry queue); an escape marker or an empty data item queues nothing.
// The back end loads one job at a time and shifts out its nibbles in order,
// pairing them into bytes (an error or flush job takes a single step); it
// loads the next job only when the current one is done.
// Reset (rst, synchronous) clears the queue, the pending nibble and the
// escape flag. A stalled result holds the back end; the front keeps taking
// transactions until the queue is full.

module nibble_stream_packer (
  input  wire logic    clk,
  input  wire logic    rst,
  nsp_item_if.sink     item,
  nsp_result_if.source result
);

  nsp_pkg::queue_wr_t   q_wr;
  nsp_pkg::queue_stat_t q_stat;
  nsp_pkg::job_t        q_head;
  logic                 q_pop;

  // Front: accept, track escapes, turn transactions into jobs for the queue.
  nsp_front u_front (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .q_stat (q_stat),
    .q_wr   (q_wr)
  );

  // Decoupling queue between front and back.
  nsp_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .wr   (q_wr),
    .pop  (q_pop),
    .head (q_head),
    .stat (q_stat)
  );

  // Back: pack nibbles into bytes, one nibble per cycle while the result is not stalled, with output register.
  nsp_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (q_head),
    .q_stat (q_stat),
    .pop    (q_pop),
    .result (result)
  );

endmodule

`default_nettype wire
